FILE: hdl/udq_pkg.sv
// Shared types and constants for the unsigned divider.
`timescale 1ns / 1ps

package udq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // top -> core handshake
  typedef struct packed {
    logic start;  // load new operands
    logic take;   // result moved to output register
  } div_ctl_t;

  // core -> top status
  typedef struct packed {
    logic idle;   // ready for operands
    logic done;   // result held, waiting to be taken
  } div_stat_t;

endpackage

FILE: hdl/udq_ifs.sv
// Valid/ready channel interfaces for divider operands and results.
`timescale 1ns / 1ps

interface udq_in_if ();
  logic           valid;
  logic           ready;
  udq_pkg::data_t dividend;
  udq_pkg::data_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udq_out_if ();
  logic           valid;
  logic           ready;
  udq_pkg::data_t quotient;
  udq_pkg::data_t remainder;
  logic           divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

FILE: hdl/udq_div_core.sv
// Radix-2 restoring divide iterator: one quotient bit per cycle.
`timescale 1ns / 1ps

module udq_div_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  udq_pkg::div_ctl_t    ctl,
  input  udq_pkg::data_t       dividend,
  input  udq_pkg::data_t       divisor,
  output udq_pkg::div_stat_t   stat,
  output udq_pkg::data_t       quotient,
  output udq_pkg::data_t       remainder,
  output logic                 divide_by_zero
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t         state_r;
  udq_pkg::data_t rem_r;
  udq_pkg::data_t quo_r;   // dividend bits shift out the top, quotient bits in the bottom
  udq_pkg::data_t dvs_r;
  udq_pkg::cnt_t  cnt_r;
  logic           dbz_r;

  logic [udq_pkg::DATA_WIDTH:0] partial;
  logic [udq_pkg::DATA_WIDTH:0] diff;
  logic                         fits;
  udq_pkg::data_t               rem_nxt;

  // partial < 2*divisor, so the restored or reduced value always fits DATA_WIDTH bits.
  // A zero divisor falls out naturally: all ones quotient, dividend as remainder.
  always_comb begin
    partial = {rem_r, quo_r[udq_pkg::DATA_WIDTH-1]};
    diff    = partial - {1'b0, dvs_r};
    fits    = (partial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[udq_pkg::DATA_WIDTH-1:0] : partial[udq_pkg::DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (ctl.start) begin
            rem_r   <= '0;
            quo_r   <= dividend;
            dvs_r   <= divisor;
            dbz_r   <= (divisor == '0);
            cnt_r   <= udq_pkg::cnt_t'(udq_pkg::DATA_WIDTH - 1);
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[udq_pkg::DATA_WIDTH-2:0], fits};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctl.take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.idle      = (state_r == ST_IDLE);
  assign stat.done      = (state_r == ST_DONE);
  assign quotient       = quo_r;
  assign remainder      = rem_r;
  assign divide_by_zero = dbz_r;

endmodule

FILE: hdl/unsigned_divider_quot_rem.sv
// Top level of the unsigned divider: operand intake, iterator and result register.
`timescale 1ns / 1ps

// Unsigned restoring divider. Each item on in_ch carries a dividend and a divisor;
// one item comes back on out_ch with the quotient, the remainder and a divide-by-zero
// flag. One item is in the divider at a time: it is accepted while the divider is idle,
// the shared subtract-and-shift unit then settles one quotient bit per cycle for all
// DATA_WIDTH bits, and the result is then handed to the output register; only after
// that hand-over can a new item be taken, and the hand-over waits while out_ch stalls. A
// result may wait in the output register while the next item is being divided. A
// zero divisor gives an all-ones quotient, the dividend as remainder and the flag set.
module unsigned_divider_quot_rem (
  input  logic        clk,
  input  logic        rst_n,
  udq_in_if.sink      in_ch,
  udq_out_if.source   out_ch
);

  udq_pkg::div_ctl_t  ctl;
  udq_pkg::div_stat_t stat;
  udq_pkg::data_t     core_quo;
  udq_pkg::data_t     core_rem;
  logic               core_dbz;

  logic               out_valid_r;
  udq_pkg::data_t     out_quo_r;
  udq_pkg::data_t     out_rem_r;
  logic               out_dbz_r;

  assign in_ch.ready = stat.idle;
  assign ctl.start   = in_ch.valid & stat.idle;
  assign ctl.take    = stat.done & (~out_valid_r | out_ch.ready);

  udq_div_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .dividend       (in_ch.dividend),
    .divisor        (in_ch.divisor),
    .stat           (stat),
    .quotient       (core_quo),
    .remainder      (core_rem),
    .divide_by_zero (core_dbz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.take) begin
        out_valid_r <= 1'b1;
        out_quo_r   <= core_quo;
        out_rem_r   <= core_rem;
        out_dbz_r   <= core_dbz;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.quotient       = out_quo_r;
  assign out_ch.remainder      = out_rem_r;
  assign out_ch.divide_by_zero = out_dbz_r;

endmodule

FILE: tb/sv/tb_unsigned_divider_quot_rem.sv
// Testbench for the unsigned divider: directed and random items checked against a local model.
`timescale 1ns / 1ps

module tb_unsigned_divider_quot_rem;

  localparam int MAX_CYCLES   = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 800;

  typedef struct packed {
    udq_pkg::data_t quotient;
    udq_pkg::data_t remainder;
    logic           divide_by_zero;
  } quot_rem_t;

  logic clk = 1'b0;
  logic rst_n;

  udq_in_if  in_ch ();
  udq_out_if out_ch ();

  unsigned_divider_quot_rem u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quot_rem_t pending_quot_rem[$];
  int        fail_count    = 0;
  int        cycle_count   = 0;
  int        src_idle_pct  = 0;
  int        sink_idle_pct = 0;
  int        hold_asked    = 0;
  int        hold_taken    = 0;
  int        hold_left     = 0;

  always #5 clk = ~clk;

  // Restoring division with a partial remainder one bit wider than the operands.
  function automatic quot_rem_t restoring_divide(udq_pkg::data_t dividend,
                                                 udq_pkg::data_t divisor);
    logic [udq_pkg::DATA_WIDTH:0] partial;
    quot_rem_t                    res;
    if (divisor == '0) begin
      res.quotient       = '1;
      res.remainder      = dividend;
      res.divide_by_zero = 1'b1;
      return res;
    end
    partial      = '0;
    res.quotient = '0;
    for (int i = udq_pkg::DATA_WIDTH - 1; i >= 0; i--) begin
      partial = {partial[udq_pkg::DATA_WIDTH-1:0], dividend[i]};
      if (partial >= {1'b0, divisor}) begin
        partial        = partial - {1'b0, divisor};
        res.quotient[i] = 1'b1;
      end
    end
    res.remainder      = partial[udq_pkg::DATA_WIDTH-1:0];
    res.divide_by_zero = 1'b0;
    return res;
  endfunction

  function automatic udq_pkg::data_t random_operand();
    int unsigned mode;
    mode = $urandom_range(9);
    case (mode)
      0: return '0;
      1, 2: return udq_pkg::data_t'($urandom_range(255));
      3, 4: return udq_pkg::data_t'($urandom >> $urandom_range(udq_pkg::DATA_WIDTH - 1));
      default: return udq_pkg::data_t'($urandom);
    endcase
  endfunction

  // Sends one item; valid stays high after acceptance so back-to-back items need no gap.
  task automatic send_operands(udq_pkg::data_t dividend, udq_pkg::data_t divisor);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= dividend;
    in_ch.divisor  <= divisor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_quot_rem.push_back(restoring_divide(dividend, divisor));
  endtask

  // Sender pauses until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_quot_rem.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    quot_rem_t want;
    if (pending_quot_rem.size() == 0) begin
      $display("%0t: result with nothing outstanding: q=%h r=%h dz=%b", $time,
               out_ch.quotient, out_ch.remainder, out_ch.divide_by_zero);
      fail_count++;
      return;
    end
    want = pending_quot_rem.pop_front();
    if (out_ch.quotient !== want.quotient) begin
      $display("%0t: quotient expected %h, got %h", $time, want.quotient, out_ch.quotient);
      fail_count++;
    end
    if (out_ch.remainder !== want.remainder) begin
      $display("%0t: remainder expected %h, got %h", $time, want.remainder,
               out_ch.remainder);
      fail_count++;
    end
    if (out_ch.divide_by_zero !== want.divide_by_zero) begin
      $display("%0t: divide_by_zero expected %b, got %b", $time, want.divide_by_zero,
               out_ch.divide_by_zero);
      fail_count++;
    end
  endtask

  // Result side: checks each item, applies random stalls and requested long holds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_asked != hold_taken) begin
        hold_taken   <= hold_asked;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_corner_cases();
    src_idle_pct  = 18;
    sink_idle_pct = 51;
    // zero divisor
    send_operands(32'h0000_0000, 32'h0000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0000);
    send_operands(32'h1234_5678, 32'h0000_0000);
    // dividend below divisor
    send_operands(32'h0000_0000, 32'h0000_0001);
    send_operands(32'h0000_0000, 32'hFFFF_FFFF);
    send_operands(32'h0000_0005, 32'h0000_0007);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'h7FFF_FFFF, 32'h8000_0000);
    // divisor equal to dividend
    send_operands(32'h0000_0001, 32'h0000_0001);
    send_operands(32'h0000_1234, 32'h0000_1234);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'h8000_0000, 32'h8000_0000);
    // large operands, some with the top divisor bit set
    send_operands(32'hFFFF_FFFF, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'h0000_0002);
    send_operands(32'hFFFF_FFFF, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'h8000_0001);
    send_operands(32'h8000_0000, 32'h0000_0001);
    send_operands(32'h8000_0000, 32'h0000_0003);
    send_operands(32'hDEAD_BEEF, 32'h0000_000A);
    send_operands(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();
  endtask

  task automatic test_random_items(int count, int src_pct, int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_operands(random_operand(), random_operand());
    drain_results();
  endtask

  // Long receiver hold while the sender keeps offering: the divider fills and stalls intake.
  task automatic test_output_hold();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_asked   <= hold_asked + 1;
    repeat (8) send_operands(udq_pkg::data_t'($urandom),
                             udq_pkg::data_t'($urandom_range(1, 65535)));
    drain_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_items(RANDOM_ITEMS / 3, 18, 51);
    test_random_items(RANDOM_ITEMS / 3, 51, 18);
    test_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);
    test_output_hold();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_quot_rem.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/udq_pkg.sv
hdl/udq_ifs.sv
hdl/udq_div_core.sv
hdl/unsigned_divider_quot_rem.sv
tb/sv/tb_unsigned_divider_quot_rem.sv
